// File: hw/rtl/energy_accumulator_kwh_defines.svh
// assertion macros for the energy accumulator
`ifndef ENERGY_ACCUMULATOR_KWH_DEFINES_SVH
`define ENERGY_ACCUMULATOR_KWH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define EAK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("energy accumulator check failed");

// next-cycle implication, sampled on clk, off during reset
`define EAK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("energy accumulator check failed");

`endif

// File: hw/rtl/eak_pkg.sv
// shared types and constants of the energy accumulator
package eak_pkg;

  localparam int POWER_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 32;

  localparam int CMD_W   = 2;
  localparam int WATTS_W = 16;
  localparam int LWH_W   = 16;
  localparam int LKWH_W  = 16;
  localparam int TOT_W   = 26;
  localparam int CNT_W   = 8;
  localparam int DIV_W   = 24;

  localparam int KWH_WH = 1000;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

  localparam logic [1:0] REG_TPS = 2'd0;
  localparam logic [1:0] REG_SPU = 2'd1;
  localparam logic [1:0] REG_DIV = 2'd2;

  localparam logic [CNT_W-1:0] TPS_RST = 8'd60;
  localparam logic [CNT_W-1:0] SPU_RST = 8'd60;
  localparam logic [DIV_W-1:0] DIV_RST = 24'd216000;

  typedef struct packed {
    logic [CNT_W-1:0] tps;
    logic [CNT_W-1:0] spu;
    logic [DIV_W-1:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic div_busy;
  } core_stat_t;

endpackage

// File: hw/rtl/eak_if.sv
// input and result channel interfaces of the energy accumulator
interface eak_in_if;
  logic                        valid;
  logic                        ready;
  logic [eak_pkg::CMD_W-1:0]   command;
  logic [eak_pkg::WATTS_W-1:0] watts;
  logic [eak_pkg::LWH_W-1:0]   stored_wh;
  logic                        stored_wh_ok;
  logic [eak_pkg::LKWH_W-1:0]  stored_kwh;
  logic                        stored_kwh_ok;

  modport source (output valid, command, watts, stored_wh, stored_wh_ok, stored_kwh,
                  stored_kwh_ok, input ready);
  modport sink (input valid, command, watts, stored_wh, stored_wh_ok, stored_kwh,
                stored_kwh_ok, output ready);
endinterface

interface eak_out_if;
  logic                       valid;
  logic                       ready;
  logic                       write_wh_record;
  logic                       write_kwh_record;
  logic [eak_pkg::LWH_W-1:0]  lifetime_wh;
  logic [eak_pkg::LKWH_W-1:0] lifetime_kwh;
  logic [eak_pkg::TOT_W-1:0]  lifetime_total_wh;

  modport source (output valid, write_wh_record, write_kwh_record, lifetime_wh,
                  lifetime_kwh, lifetime_total_wh, input ready);
  modport sink (input valid, write_wh_record, write_kwh_record, lifetime_wh,
                lifetime_kwh, lifetime_total_wh, output ready);
endinterface

// File: hw/rtl/eak_cfg.sv
// apb-style configuration registers
module eak_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eak_pkg::ADDR_W-1:0]  paddr,
  input  logic [eak_pkg::DATA_W-1:0]  pwdata,
  output logic [eak_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output eak_pkg::cfg_t               cfg
);

  logic [eak_pkg::CNT_W-1:0] tps_r;
  logic [eak_pkg::CNT_W-1:0] spu_r;
  logic [eak_pkg::DIV_W-1:0] dvs_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= eak_pkg::TPS_RST;
      spu_r <= eak_pkg::SPU_RST;
      dvs_r <= eak_pkg::DIV_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        eak_pkg::REG_TPS: tps_r <= pwdata[eak_pkg::CNT_W-1:0];
        eak_pkg::REG_SPU: spu_r <= pwdata[eak_pkg::CNT_W-1:0];
        eak_pkg::REG_DIV: dvs_r <= pwdata[eak_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      eak_pkg::REG_TPS: prdata = eak_pkg::DATA_W'(tps_r);
      eak_pkg::REG_SPU: prdata = eak_pkg::DATA_W'(spu_r);
      eak_pkg::REG_DIV: prdata = eak_pkg::DATA_W'(dvs_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.tps     = tps_r;
  assign cfg.spu     = spu_r;
  assign cfg.divisor = dvs_r;

endmodule

// File: hw/rtl/eak_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module eak_div #(
  parameter int DW = eak_pkg::SUM_BITS_DEF + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [eak_pkg::DIV_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DW-1:0]              quotient,
  output logic [eak_pkg::DIV_W-1:0]  remainder
);

  localparam int CW  = $clog2(DW + 1);
  localparam int DVW = eak_pkg::DIV_W;

  logic [DW-1:0]  acc_r, acc_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   shifted;
  logic [DVW:0]   diff;
  logic           ge;

  assign shifted = {rem_r, acc_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[DW-2:0], ge};
      rem_nxt = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = acc_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/eak_core.sv
// accumulator state, command sequencer and result register
module eak_core #(
  parameter int POWER_BITS = eak_pkg::POWER_BITS_DEF,
  parameter int SUM_BITS   = eak_pkg::SUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  eak_pkg::cfg_t       cfg,
  eak_in_if.sink              in_ch,
  eak_out_if.source           out_ch,
  output eak_pkg::core_stat_t stat
);

  localparam int DW     = SUM_BITS + 1;
  localparam int PW_EFF = (POWER_BITS < eak_pkg::WATTS_W) ? POWER_BITS : eak_pkg::WATTS_W;
  localparam int LWH    = eak_pkg::LWH_W;
  localparam int LKWH   = eak_pkg::LKWH_W;
  localparam int CW     = eak_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  // latched item
  logic [eak_pkg::CMD_W-1:0]   cmd_r;
  logic [eak_pkg::WATTS_W-1:0] watts_r;
  logic [LWH-1:0]              swh_r;
  logic                        swh_ok_r;
  logic [LKWH-1:0]             skwh_r;
  logic                        skwh_ok_r;

  logic [CW-1:0]       tick_cnt_r, tick_cnt_nxt;
  logic [SUM_BITS-1:0] sec_sum_r, sec_sum_nxt;
  logic [CW-1:0]       sec_cnt_r, sec_cnt_nxt;
  logic [SUM_BITS-1:0] int_sum_r, int_sum_nxt;
  logic [LWH-1:0]      life_wh_r, life_wh_nxt;
  logic [LKWH-1:0]     life_kwh_r, life_kwh_nxt;
  logic                wflag_r, wflag_nxt;
  logic                kflag_r, kflag_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_wflag_r;
  logic                       out_kflag_r;
  logic [LWH-1:0]             out_wh_r;
  logic [LKWH-1:0]            out_kwh_r;
  logic [eak_pkg::TOT_W-1:0]  out_tot_r;
  logic                       out_load;
  logic [eak_pkg::TOT_W-1:0]  tot_calc;

  logic                      in_acc;
  logic                      div_start;
  logic [DW-1:0]             div_dend;
  logic [eak_pkg::DIV_W-1:0] div_dvs;
  logic [eak_pkg::DIV_W-1:0] cfg_dvs;
  logic                      div_busy;
  logic                      div_done;
  logic [DW-1:0]             div_quo;
  logic [eak_pkg::DIV_W-1:0] div_rem;

  logic [SUM_BITS-1:0] watts_ext;
  logic [SUM_BITS:0]   ss_wide;
  logic [SUM_BITS-1:0] ss_sum;
  logic [SUM_BITS:0]   is_wide;
  logic [SUM_BITS-1:0] is_sum;
  logic [CW-1:0]       tc_inc;
  logic [CW-1:0]       sc_inc;
  logic [DW-1:0]       total;
  logic [LKWH:0]       kwh_wide;
  logic [LKWH-1:0]     kwh_sat;

  eak_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dend),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign watts_ext = {{(SUM_BITS-PW_EFF){1'b0}}, watts_r[PW_EFF-1:0]};
  assign ss_wide   = {1'b0, sec_sum_r} + {1'b0, watts_ext};
  assign ss_sum    = ss_wide[SUM_BITS] ? '1 : ss_wide[SUM_BITS-1:0];
  assign is_wide   = {1'b0, int_sum_r} + {1'b0, ss_sum};
  assign is_sum    = is_wide[SUM_BITS] ? '1 : is_wide[SUM_BITS-1:0];
  assign tc_inc    = tick_cnt_r + CW'(1);
  assign sc_inc    = sec_cnt_r + CW'(1);
  assign cfg_dvs   = (cfg.divisor == '0) ? eak_pkg::DIV_W'(1) : cfg.divisor;

  assign total    = {{(DW-LWH){1'b0}}, life_wh_r} + div_quo;
  assign kwh_wide = {1'b0, life_kwh_r} + {1'b0, div_quo[LKWH-1:0]};
  assign kwh_sat  = ((|div_quo[DW-1:LKWH]) || kwh_wide[LKWH]) ? '1 : kwh_wide[LKWH-1:0];

  assign tot_calc = eak_pkg::TOT_W'(life_wh_r)
                  + eak_pkg::TOT_W'(life_kwh_r) * eak_pkg::TOT_W'(eak_pkg::KWH_WH);

  always_comb begin
    state_nxt    = state_r;
    tick_cnt_nxt = tick_cnt_r;
    sec_sum_nxt  = sec_sum_r;
    sec_cnt_nxt  = sec_cnt_r;
    int_sum_nxt  = int_sum_r;
    life_wh_nxt  = life_wh_r;
    life_kwh_nxt = life_kwh_r;
    wflag_nxt    = wflag_r;
    kflag_nxt    = kflag_r;
    div_start    = 1'b0;
    div_dend     = {1'b0, is_sum};
    div_dvs      = cfg_dvs;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wflag_nxt = 1'b0;
        kflag_nxt = 1'b0;
        state_nxt = ST_EMIT;
        case (cmd_r)
          eak_pkg::CMD_TICK: begin
            if (tc_inc >= cfg.tps) begin
              sec_sum_nxt  = '0;
              tick_cnt_nxt = '0;
              if (sc_inc >= cfg.spu) begin
                div_start   = 1'b1;
                sec_cnt_nxt = '0;
                int_sum_nxt = '0;
                state_nxt   = ST_DIV1;
              end else begin
                sec_cnt_nxt = sc_inc;
                int_sum_nxt = is_sum;
              end
            end else begin
              sec_sum_nxt  = ss_sum;
              tick_cnt_nxt = tc_inc;
            end
          end
          eak_pkg::CMD_CLEAR: begin
            tick_cnt_nxt = '0;
            sec_sum_nxt  = '0;
            sec_cnt_nxt  = '0;
            int_sum_nxt  = '0;
            life_wh_nxt  = '0;
            life_kwh_nxt = '0;
            wflag_nxt    = 1'b1;
            kflag_nxt    = 1'b1;
          end
          eak_pkg::CMD_RESTORE: begin
            life_wh_nxt  = swh_ok_r ? swh_r : '0;
            wflag_nxt    = !swh_ok_r;
            life_kwh_nxt = skwh_ok_r ? skwh_r : '0;
            kflag_nxt    = !skwh_ok_r;
          end
          default: ;
        endcase
      end
      ST_DIV1: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
          if (div_quo != '0) begin
            if (total >= DW'(eak_pkg::KWH_WH)) begin
              div_start = 1'b1;
              div_dend  = total;
              div_dvs   = eak_pkg::DIV_W'(eak_pkg::KWH_WH);
              state_nxt = ST_DIV2;
            end else begin
              life_wh_nxt = total[LWH-1:0];
              wflag_nxt   = 1'b1;
            end
          end
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          life_kwh_nxt = kwh_sat;
          life_wh_nxt  = LWH'(div_rem);
          wflag_nxt    = 1'b1;
          kflag_nxt    = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_cnt_r  <= '0;
      sec_sum_r   <= '0;
      sec_cnt_r   <= '0;
      int_sum_r   <= '0;
      life_wh_r   <= '0;
      life_kwh_r  <= '0;
      wflag_r     <= 1'b0;
      kflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      sec_sum_r   <= sec_sum_nxt;
      sec_cnt_r   <= sec_cnt_nxt;
      int_sum_r   <= int_sum_nxt;
      life_wh_r   <= life_wh_nxt;
      life_kwh_r  <= life_kwh_nxt;
      wflag_r     <= wflag_nxt;
      kflag_r     <= kflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_ch.command;
      watts_r   <= in_ch.watts;
      swh_r     <= in_ch.stored_wh;
      swh_ok_r  <= in_ch.stored_wh_ok;
      skwh_r    <= in_ch.stored_kwh;
      skwh_ok_r <= in_ch.stored_kwh_ok;
    end
    if (out_load) begin
      out_wflag_r <= wflag_r;
      out_kflag_r <= kflag_r;
      out_wh_r    <= life_wh_r;
      out_kwh_r   <= life_kwh_r;
      out_tot_r   <= tot_calc;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.write_wh_record   = out_wflag_r;
  assign out_ch.write_kwh_record  = out_kflag_r;
  assign out_ch.lifetime_wh       = out_wh_r;
  assign out_ch.lifetime_kwh      = out_kwh_r;
  assign out_ch.lifetime_total_wh = out_tot_r;

  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.div_busy = div_busy;

endmodule

// File: hw/rtl/energy_accumulator_kwh.sv
// top level of the lifetime energy meter
// in_ch carries one command beat: tick with a watts sample, clear, or restore of the
// stored watt-hour and kilowatt-hour records with their checksum flags.
// out_ch returns exactly one result beat per command: the record write flags and
// the lifetime watt-hours, kilowatt-hours and their combined total.
// the apb-style port holds ticks per second, seconds per update and the divisor;
// write it only while no command is in flight.
// a plain tick, a clear or a restore goes from accept through the exec and emit states,
// and the sequencer returns to idle for the next command once its result is loaded.
// a tick that closes an update interval runs the bit-serial divider, one quotient
// bit per cycle over SUM_BITS+1 bits, once for watt-hours and once more by 1000
// when a thousand carries, before the emit state loads the result.
// one command is in work at a time.
// in_ch.ready is high only when the sequencer is idle; the result register lets a
// new command start while the last result still waits on out_ch.
// a stalled receiver holds the result in place and the next result waits for it.
// reset (synchronous, rst_n low) clears all sums, counters and lifetime records and
// loads the register defaults; no result is pending after reset.
`include "energy_accumulator_kwh_defines.svh"

module energy_accumulator_kwh #(
  parameter int POWER_BITS = eak_pkg::POWER_BITS_DEF,
  parameter int SUM_BITS   = eak_pkg::SUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  eak_in_if.sink                      in_ch,
  eak_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eak_pkg::ADDR_W-1:0]  paddr,
  input  logic [eak_pkg::DATA_W-1:0]  pwdata,
  output logic [eak_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  eak_pkg::cfg_t       cfg;
  eak_pkg::core_stat_t stat;

  eak_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eak_core #(
    .POWER_BITS (POWER_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .stat   (stat)
  );

  `EAK_ASSERT_NEXT(a_accept_starts_work, in_ch.valid && in_ch.ready, !stat.idle)
  `EAK_ASSERT_NOW(a_idle_div_quiet, stat.idle, !stat.div_busy)
  `EAK_ASSERT_NOW(a_ready_only_idle, in_ch.ready, stat.idle)
  `EAK_ASSERT_NOW(a_total_matches, out_ch.valid,
    out_ch.lifetime_total_wh == (eak_pkg::TOT_W'(out_ch.lifetime_wh) +
      eak_pkg::TOT_W'(out_ch.lifetime_kwh) * eak_pkg::TOT_W'(eak_pkg::KWH_WH)))

endmodule
